>>> src/u8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder.
// Holds result codes, register map constants and the state/result structs.
// No dependencies.
package u8u16_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned UNIT_W   = 16;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] LIMIT_CEIL = 7'd126;
    localparam logic [COUNT_W-1:0] MAX_UNITS_RESET = 7'd126;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_UNITS = 1'b0;

    typedef enum logic [1:0] {
        KIND_UNIT  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]         pending;
        logic [UNIT_W-1:0]  partial;
        logic               three;
        logic [COUNT_W-1:0] units;
        logic               over;
    } dec_state_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [UNIT_W-1:0]  code_unit;
        logic [COUNT_W-1:0] unit_count;
        logic               last;
    } dec_result_t;

endpackage

>>> src/utf8_to_utf16_transcoder_top.sv
// Top level of the UTF-8 to UTF-16 transcoder: handshakes, config register, result register.
// Depends on u8u16_pkg and u8u16_step.
//
// Takes one UTF-8 byte per cycle while s_ready is high and returns one result per completed
// 1-, 2- or 3-byte sequence (a code unit), or an end or error result that closes the string;
// bytes after the end are dropped until a byte marked string_start. The decode step is a
// single combinational pass from the decoder state registers into the result register, so
// a byte is taken every cycle unless a result sits unclaimed in the result register while
// m_ready is low. Results appear in the cycle after the byte that causes them. max_units
// (address 0) caps the units per string; 127 acts as 126.
module utf8_to_utf16_transcoder_top (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8u16_pkg::PADDR_W-1:0]   paddr,
    input  logic [u8u16_pkg::PDATA_W-1:0]   pwdata,
    output logic [u8u16_pkg::PDATA_W-1:0]   prdata,
    output logic                            pready,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]    s_data_byte,
    input  logic                            s_string_start,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_kind,
    output logic [u8u16_pkg::UNIT_W-1:0]    m_code_unit,
    output logic [u8u16_pkg::COUNT_W-1:0]   m_unit_count,
    output logic                            m_last
);
    import u8u16_pkg::*;

    logic [COUNT_W-1:0] max_units_reg;
    logic [COUNT_W-1:0] limit;
    logic               cfg_wr;

    dec_state_t         state_reg;
    dec_state_t         state_next;
    dec_result_t        step_res;

    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [UNIT_W-1:0]  out_unit_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    logic               s_fire;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_UNITS);
    assign prdata = (paddr[2] == REG_MAX_UNITS) ? {25'b0, max_units_reg} : '0;
    assign limit  = (max_units_reg > LIMIT_CEIL) ? LIMIT_CEIL : max_units_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_units_reg <= MAX_UNITS_RESET;
        end else if (cfg_wr) begin
            max_units_reg <= pwdata[COUNT_W-1:0];
        end
    end

    u8u16_step u_step (
        .state        (state_reg),
        .data_byte    (s_data_byte),
        .string_start (s_string_start),
        .limit        (limit),
        .state_next   (state_next),
        .result       (step_res)
    );

    assign s_ready = !out_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= '{pending: 2'd0, partial: '0, three: 1'b0, units: '0,
                                over: 1'b1};
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg     <= state_next;
                out_valid_reg <= step_res.valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && step_res.valid) begin
            out_kind_reg  <= step_res.kind;
            out_unit_reg  <= step_res.code_unit;
            out_count_reg <= step_res.unit_count;
            out_last_reg  <= step_res.last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_code_unit  = out_unit_reg;
    assign m_unit_count = out_count_reg;
    assign m_last       = out_last_reg;

    a_nonunit_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_UNIT) |-> (m_last && m_code_unit == '0))
        else $error("end or error result without last or with nonzero unit");

    a_unit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_UNIT) |-> (m_unit_count != '0))
        else $error("code unit transfer with zero unit count");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && step_res.valid && step_res.last) |=> state_reg.over)
        else $error("string not closed after last result");

    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.pending != 2'd3))
        else $error("continuation count out of range");

endmodule

>>> src/u8u16_step.sv
// Per-byte decode step of the UTF-8 to UTF-16 transcoder.
// Combinational: current state and byte in, next state and optional result out.
// Depends on u8u16_pkg.
module u8u16_step (
    input  u8u16_pkg::dec_state_t          state,
    input  logic [u8u16_pkg::BYTE_W-1:0]   data_byte,
    input  logic                           string_start,
    input  logic [u8u16_pkg::COUNT_W-1:0]  limit,
    output u8u16_pkg::dec_state_t          state_next,
    output u8u16_pkg::dec_result_t         result
);
    import u8u16_pkg::*;

    dec_state_t         cur;
    logic [UNIT_W-1:0]  point;
    logic [COUNT_W-1:0] units_inc;
    logic               emit;
    logic               fail;
    logic               ended;

    assign units_inc = cur.units + 7'd1;

    always_comb begin
        cur = state;
        if (string_start) begin
            cur = '0;
        end

        state_next = cur;
        point = '0;
        emit  = 1'b0;
        fail  = 1'b0;
        ended = 1'b0;

        if (!cur.over) begin
            if (cur.pending == 2'd0) begin
                if (cur.units >= limit) begin
                    state_next.over = 1'b1;
                end else if (data_byte == 8'h00) begin
                    ended = 1'b1;
                end else if (!data_byte[7]) begin
                    point = {8'h00, data_byte};
                    emit  = 1'b1;
                end else if (data_byte[7:5] == 3'b110) begin
                    state_next.partial = {5'b0, data_byte[4:0], 6'b0};
                    state_next.pending = 2'd1;
                    state_next.three   = 1'b0;
                end else if (data_byte[7:4] == 4'b1110) begin
                    state_next.partial = {data_byte[3:0], 12'b0};
                    state_next.pending = 2'd2;
                    state_next.three   = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end else begin
                if (data_byte[7:6] != 2'b10) begin
                    state_next.pending = 2'd0;
                    fail = 1'b1;
                end else if (cur.pending >= 2'd2) begin
                    state_next.partial = cur.partial | {4'b0, data_byte[5:0], 6'b0};
                    state_next.pending = 2'd1;
                end else begin
                    point = cur.partial | {10'b0, data_byte[5:0]};
                    state_next.partial = point;
                    state_next.pending = 2'd0;
                    // surrogate range D800-DFFF
                    if (cur.three && point[15:11] == 5'b11011) begin
                        fail = 1'b1;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
        end

        result.valid      = emit || fail || ended;
        result.kind       = KIND_UNIT;
        result.code_unit  = '0;
        result.unit_count = cur.units;
        result.last       = 1'b1;

        if (emit) begin
            state_next.units  = units_inc;
            result.code_unit  = point;
            result.unit_count = units_inc;
            result.last       = units_inc >= limit;
            state_next.over   = units_inc >= limit;
        end else if (fail) begin
            result.kind     = KIND_ERROR;
            state_next.over = 1'b1;
        end else if (ended) begin
            result.kind     = KIND_END;
            state_next.over = 1'b1;
        end
    end

endmodule
